// ----- hdl/oat_pkg.sv -----
`timescale 1ns / 1ps

package oat_pkg;

  localparam int unsigned SLOTS_DEF = 4;
  localparam logic [19:0] TPM_RESET = 20'd52000;

  localparam logic [1:0] ACT_SET    = 2'd0;
  localparam logic [1:0] ACT_SLEEP  = 2'd1;
  localparam logic [1:0] ACT_CANCEL = 2'd2;
  localparam logic [1:0] ACT_TICK   = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  typedef struct packed {
    logic [1:0]  act;
    logic        who;
    logic [31:0] arg;
    logic [31:0] cb;
    logic [63:0] now;
    logic [63:0] dl;
  } req_t;

  typedef struct packed {
    logic        grab;
    logic        cancel_ok;
    logic        fire;
    logic [31:0] cb;
  } evt_t;

endpackage

// ----- hdl/one_shot_alarm_table_unit.sv -----
`timescale 1ns / 1ps
// One-shot alarm table for two programs.
// Input channel (in_valid / in_stall): one request word per item: set, sleep,
// cancel or timer tick, with caller, argument, callback and the current time.
// Result channel (out_valid / out_stall): set, sleep and cancel give one word;
// a tick gives one word per expired alarm of the caller in slot order, with
// out_last on the final one, and no word when nothing expires.
// Config channel (cfg_valid / cfg_ready): writes ticks_per_ms; always ready.
// Steps: an item passes a multiply step and a 64-bit add step; the request
// token then walks the chain of slot cells one slot at a time, followed by a
// finishing step and an idle step before the next acceptance; a zero-delay
// sleep goes straight to the finishing step. Results are registered: a set,
// sleep or cancel word enters the output register in the finishing step.
// Fired alarms of a tick leave as the token passes their slot, one word behind.
// Reset clears all armed bits, sets ticks_per_ms to 52000 and empties the
// output register. A stalled result holds the token in place; the chain
// resumes as soon as the output register can take a new word.
module one_shot_alarm_table_unit #(
  parameter int unsigned ALARM_SLOTS = oat_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic        in_caller_id,
  input  logic [31:0] in_argument,
  input  logic [31:0] in_callback_in,
  input  logic [63:0] in_now_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [1:0]  out_alarm_number,
  output logic        out_fired,
  output logic [31:0] out_callback_out,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [19:0] cfg_ticks_per_ms
);
  import oat_pkg::*;

  localparam int unsigned IW = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]    st_r, st_nxt;
  logic [19:0]   tpm_r;
  logic [1:0]    act_r;
  logic          who_r;
  logic [31:0]   arg_r, cb_r;
  logic [63:0]   now_r, dl_r;
  logic [51:0]   prod_r;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          got_r, got_nxt;
  logic [IW-1:0] slot_r, slot_nxt;
  logic          cok_r, cok_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic [IW-1:0] pend_slot_r, pend_slot_nxt;
  logic [31:0]   pend_cb_r, pend_cb_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [1:0]    out_num_r, out_num_nxt;
  logic          out_fired_r, out_fired_nxt;
  logic [31:0]   out_cb_r, out_cb_nxt;
  logic          out_last_r, out_last_nxt;
  logic          push;

  logic          accept, adv, done;
  logic          ev_grab, ev_cok, ev_fire;
  logic [31:0]   ev_cb;
  req_t          req;
  evt_t          evt_a   [ALARM_SLOTS];
  logic [ALARM_SLOTS-1:0] hit_v;
  logic          tok_c   [ALARM_SLOTS+1];
  logic          claim_c [ALARM_SLOTS+1];

  assign in_stall  = (st_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign adv       = !out_valid_r || !out_stall;

  assign req.act = act_r;
  assign req.who = who_r;
  assign req.arg = arg_r;
  assign req.cb  = cb_r;
  assign req.now = now_r;
  assign req.dl  = dl_r;

  assign tok_c[0]   = (st_r == S_ADD);
  assign claim_c[0] = 1'b0;
  assign done       = tok_c[ALARM_SLOTS];

  for (genvar g = 0; g < ALARM_SLOTS; g++) begin : g_cell
    oat_cell #(.CELL_IDX(g)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .req       (req),
      .adv       (adv),
      .tok_in    (tok_c[g]),
      .claim_in  (claim_c[g]),
      .tok_out   (tok_c[g+1]),
      .claim_out (claim_c[g+1]),
      .evt       (evt_a[g])
    );
    assign hit_v[g] = evt_a[g].grab | evt_a[g].cancel_ok | evt_a[g].fire;
  end

  always_comb begin
    ev_grab = 1'b0;
    ev_cok  = 1'b0;
    ev_fire = 1'b0;
    ev_cb   = 32'd0;
    for (int i = 0; i < ALARM_SLOTS; i++) begin
      ev_grab = ev_grab | evt_a[i].grab;
      ev_cok  = ev_cok  | evt_a[i].cancel_ok;
      ev_fire = ev_fire | evt_a[i].fire;
      ev_cb   = ev_cb   | evt_a[i].cb;
    end
  end

  always_comb begin
    st_nxt        = st_r;
    idx_nxt       = idx_r;
    got_nxt       = got_r;
    slot_nxt      = slot_r;
    cok_nxt       = cok_r;
    pend_v_nxt    = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    pend_cb_nxt   = pend_cb_r;
    push          = 1'b0;
    out_status_nxt = out_status_r;
    out_num_nxt    = out_num_r;
    out_fired_nxt  = out_fired_r;
    out_cb_nxt     = out_cb_r;
    out_last_nxt   = out_last_r;

    case (st_r)
      S_IDLE: begin
        if (accept) begin
          got_nxt    = 1'b0;
          cok_nxt    = 1'b0;
          pend_v_nxt = 1'b0;
          if (in_action == ACT_SLEEP && in_argument == 32'd0) begin
            st_nxt = S_FIN;
          end else begin
            st_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        st_nxt = S_ADD;
      end
      S_ADD: begin
        idx_nxt = '0;
        st_nxt  = S_SCAN;
      end
      S_SCAN: begin
        if (adv) begin
          idx_nxt = idx_r + IW'(1);
          if (ev_grab) begin
            got_nxt  = 1'b1;
            slot_nxt = idx_r;
          end
          if (ev_cok) begin
            cok_nxt = 1'b1;
          end
          if (ev_fire) begin
            if (pend_v_r) begin
              push           = 1'b1;
              out_status_nxt = ST_OK;
              out_num_nxt    = 2'(pend_slot_r);
              out_fired_nxt  = 1'b1;
              out_cb_nxt     = pend_cb_r;
              out_last_nxt   = 1'b0;
            end
            pend_v_nxt    = 1'b1;
            pend_slot_nxt = idx_r;
            pend_cb_nxt   = ev_cb;
          end
          if (done) begin
            st_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (adv) begin
          st_nxt         = S_IDLE;
          out_fired_nxt  = 1'b0;
          out_cb_nxt     = 32'd0;
          out_last_nxt   = 1'b1;
          out_num_nxt    = 2'd0;
          out_status_nxt = ST_OK;
          case (act_r)
            ACT_SET: begin
              push           = 1'b1;
              out_status_nxt = got_r ? ST_OK : ST_FULL;
              out_num_nxt    = got_r ? 2'(slot_r) : 2'd0;
            end
            ACT_SLEEP: begin
              push           = 1'b1;
              out_status_nxt = (got_r || arg_r == 32'd0) ? ST_OK : ST_FULL;
            end
            ACT_CANCEL: begin
              push           = 1'b1;
              out_status_nxt = cok_r ? ST_OK : ST_REJECT;
            end
            default: begin
              push          = pend_v_r;
              out_num_nxt   = 2'(pend_slot_r);
              out_fired_nxt = 1'b1;
              out_cb_nxt    = pend_cb_r;
              pend_v_nxt    = 1'b0;
            end
          endcase
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase

    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      tpm_r       <= TPM_RESET;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      got_r       <= 1'b0;
      cok_r       <= 1'b0;
      idx_r       <= '0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
      got_r       <= got_nxt;
      cok_r       <= cok_nxt;
      idx_r       <= idx_nxt;
      if (cfg_valid && cfg_ready) begin
        tpm_r <= cfg_ticks_per_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_action;
      who_r <= in_caller_id;
      arg_r <= in_argument;
      cb_r  <= in_callback_in;
      now_r <= in_now_time;
    end
    if (st_r == S_MUL) begin
      prod_r <= 52'(arg_r) * 52'(tpm_r);
    end
    if (st_r == S_ADD) begin
      dl_r <= now_r + {12'd0, prod_r};
    end
    slot_r      <= slot_nxt;
    pend_slot_r <= pend_slot_nxt;
    pend_cb_r   <= pend_cb_nxt;
    if (push) begin
      out_status_r <= out_status_nxt;
      out_num_r    <= out_num_nxt;
      out_fired_r  <= out_fired_nxt;
      out_cb_r     <= out_cb_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_alarm_number = out_num_r;
  assign out_fired        = out_fired_r;
  assign out_callback_out = out_cb_r;
  assign out_last         = out_last_r;

  a_one_cell_active: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_v))
    else $error("more than one slot cell acted in one cycle");

  a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> (st_r == S_SCAN || st_r == S_FIN))
    else $error("pending fired alarm outside a scan");

  a_fire_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    ev_fire |-> (act_r == ACT_TICK && st_r == S_SCAN))
    else $error("alarm fired outside a tick scan");

  a_fin_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_FIN && adv) |=> (!pend_v_r && st_r == S_IDLE))
    else $error("finish left a pending alarm or did not return to idle");

endmodule

// ----- hdl/oat_cell.sv -----
`timescale 1ns / 1ps

module oat_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  oat_pkg::req_t req,
  input  logic          adv,
  input  logic          tok_in,
  input  logic          claim_in,
  output logic          tok_out,
  output logic          claim_out,
  output oat_pkg::evt_t evt
);
  import oat_pkg::*;

  logic        tok_r, tok_nxt;
  logic        claim_r, claim_nxt;
  logic        armed_r, armed_nxt;
  logic [63:0] dl_r;
  logic [31:0] cb_r;
  logic        own_r;
  logic        act_now, grab, hit_cancel, hit_fire;

  always_comb begin
    act_now    = tok_r & adv;
    grab       = act_now && (req.act == ACT_SET || req.act == ACT_SLEEP) &&
                 !claim_r && !armed_r;
    hit_cancel = act_now && (req.act == ACT_CANCEL) && (req.arg == 32'(CELL_IDX)) &&
                 armed_r && (own_r == req.who);
    hit_fire   = act_now && (req.act == ACT_TICK) && armed_r &&
                 (own_r == req.who) && (dl_r <= req.now);

    armed_nxt = armed_r;
    if (grab) begin
      armed_nxt = 1'b1;
    end else if (hit_cancel || hit_fire) begin
      armed_nxt = 1'b0;
    end

    tok_nxt   = tok_in ? 1'b1 : (act_now ? 1'b0 : tok_r);
    claim_nxt = tok_in ? claim_in : claim_r;

    tok_out       = act_now;
    claim_out     = claim_r | grab;
    evt.grab      = grab;
    evt.cancel_ok = hit_cancel;
    evt.fire      = hit_fire;
    evt.cb        = hit_fire ? cb_r : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r   <= 1'b0;
      claim_r <= 1'b0;
      armed_r <= 1'b0;
    end else begin
      tok_r   <= tok_nxt;
      claim_r <= claim_nxt;
      armed_r <= armed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (grab) begin
      dl_r  <= req.dl;
      cb_r  <= (req.act == ACT_SET) ? req.cb : 32'd0;
      own_r <= req.who;
    end
  end

endmodule
